FILE: src/sstq_pkg.sv
package sstq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 16;
   localparam int MAX_RESULTS = 16;
   localparam logic [15:0] TPS_RESET = 16'd1000;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [1:0] KIND_ACCEPTED = 2'd0;
   localparam logic [1:0] KIND_FULL = 2'd1;
   localparam logic [1:0] KIND_WOKEN = 2'd2;

   typedef struct packed {
      logic [31:0] wake;
      logic [7:0] tid;
   } entry_type;

   typedef struct packed {
      logic cap_insert;
      logic cap_tick;
      logic mul;
      logic add;
      logic rd_ins;
      logic shift;
      logic place;
      logic rd_cnt;
      logic cnt_inc;
      logic rd_emit;
      logic out_ins;
      logic out_wake;
      logic emit_inc;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic idx_zero;
      logic later;
      logic cnt_stop;
      logic due;
      logic out_woken;
      logic out_last;
   } status_type;

endpackage

FILE: src/sstq_req_if.sv
interface sstq_req_if;
   logic valid;
   logic ready;
   logic op;
   logic [7:0] thread_id;
   logic [15:0] delay_seconds;

   modport source (output valid, output op, output thread_id, output delay_seconds,
                   input ready);
   modport sink (input valid, input op, input thread_id, input delay_seconds,
                 output ready);
endinterface

FILE: src/sstq_rsp_if.sv
interface sstq_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] kind;
   logic [7:0] woken_thread;
   logic last_result;

   modport source (output valid, output kind, output woken_thread, output last_result,
                   input ready);
   modport sink (input valid, input kind, input woken_thread, input last_result,
                 output ready);
endinterface

FILE: src/sstq_datapath.sv
module sstq_datapath
   import sstq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   input  cmd_type cmd,
   output status_type status,
   input  logic [7:0] req_thread_id,
   input  logic [15:0] req_delay_seconds,
   input  logic csr_write_enable,
   input  logic [15:0] csr_write_data,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_woken_thread,
   output logic rsp_last_result
);

   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int SUM_W = OCC_W + 1;

   // Entries live in a ring; logical position zero is the earliest deadline.
   function automatic logic [IDX_W-1:0] ring_addr(input logic [IDX_W-1:0] base,
                                                  input logic [OCC_W-1:0] offset);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(offset);
      if (sum >= SUM_W'(QUEUE_DEPTH)) begin
         sum = sum - SUM_W'(QUEUE_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   entry_type mem_ff [QUEUE_DEPTH];
   entry_type rd_data_ff;

   logic [15:0] tps_ff, tps_in;
   logic [31:0] tick_ff, tick_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [OCC_W-1:0] idx_ff, idx_in;
   logic [OCC_W-1:0] emit_ff, emit_in;
   logic [7:0] tid_ff, tid_in;
   logic [15:0] delay_ff, delay_in;
   logic [31:0] span_ff, span_in;
   logic [31:0] wake_ff, wake_in;
   logic [1:0] out_kind_ff, out_kind_in;
   logic [7:0] out_tid_ff, out_tid_in;
   logic out_last_ff, out_last_in;

   logic [32:0] wake_sum;
   logic rd_en;
   logic [OCC_W-1:0] rd_pos;
   logic wr_en;
   entry_type wr_data;

   always_comb begin
      tps_in = csr_write_enable ? csr_write_data : tps_ff;
      tick_in = cmd.cap_tick ? tick_ff + 32'd1 : tick_ff;

      occ_in = occ_ff;
      if (cmd.place) begin
         occ_in = occ_ff + OCC_W'(1);
      end else if (cmd.commit) begin
         occ_in = occ_ff - idx_ff;
      end
      head_in = cmd.commit ? ring_addr(head_ff, idx_ff) : head_ff;

      idx_in = idx_ff;
      if (cmd.cap_tick) begin
         idx_in = '0;
      end else if (cmd.add) begin
         idx_in = occ_ff;
      end else if (cmd.shift) begin
         idx_in = idx_ff - OCC_W'(1);
      end else if (cmd.cnt_inc) begin
         idx_in = idx_ff + OCC_W'(1);
      end

      emit_in = emit_ff;
      if (cmd.cap_tick) begin
         emit_in = '0;
      end else if (cmd.emit_inc) begin
         emit_in = emit_ff + OCC_W'(1);
      end

      tid_in = cmd.cap_insert ? req_thread_id : tid_ff;
      delay_in = cmd.cap_insert ? req_delay_seconds : delay_ff;
      span_in = cmd.mul ? delay_ff * tps_ff : span_ff;

      wake_sum = {1'b0, tick_ff} + {1'b0, span_ff};
      wake_in = wake_ff;
      if (cmd.add) begin
         wake_in = wake_sum[32] ? 32'hFFFF_FFFF : wake_sum[31:0];
      end

      out_kind_in = out_kind_ff;
      out_tid_in = out_tid_ff;
      out_last_in = out_last_ff;
      if (cmd.out_ins) begin
         out_kind_in = status.full ? KIND_FULL : KIND_ACCEPTED;
         out_tid_in = 8'd0;
         out_last_in = 1'b1;
      end else if (cmd.out_wake) begin
         out_kind_in = KIND_WOKEN;
         out_tid_in = rd_data_ff.tid;
         out_last_in = (emit_ff + OCC_W'(1)) == idx_ff;
      end
   end

   always_comb begin
      rd_en = cmd.rd_ins | cmd.rd_cnt | cmd.rd_emit;
      if (cmd.rd_ins) begin
         rd_pos = idx_ff - OCC_W'(1);
      end else if (cmd.rd_cnt) begin
         rd_pos = idx_ff;
      end else begin
         rd_pos = emit_ff;
      end
      wr_en = cmd.shift | cmd.place;
      wr_data = cmd.shift ? rd_data_ff : entry_type'{wake: wake_ff, tid: tid_ff};
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[ring_addr(head_ff, idx_ff)] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[ring_addr(head_ff, rd_pos)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff <= TPS_RESET;
         tick_ff <= '0;
         occ_ff <= '0;
         head_ff <= '0;
         idx_ff <= '0;
         emit_ff <= '0;
      end else begin
         tps_ff <= tps_in;
         tick_ff <= tick_in;
         occ_ff <= occ_in;
         head_ff <= head_in;
         idx_ff <= idx_in;
         emit_ff <= emit_in;
      end
   end

   always_ff @(posedge clock) begin
      tid_ff <= tid_in;
      delay_ff <= delay_in;
      span_ff <= span_in;
      wake_ff <= wake_in;
      out_kind_ff <= out_kind_in;
      out_tid_ff <= out_tid_in;
      out_last_ff <= out_last_in;
   end

   always_comb begin
      status.full = occ_ff == OCC_W'(QUEUE_DEPTH);
      status.idx_zero = idx_ff == '0;
      status.later = rd_data_ff.wake > wake_ff;
      status.cnt_stop = (idx_ff == occ_ff) || (32'(idx_ff) == MAX_RESULTS);
      status.due = rd_data_ff.wake <= tick_ff;
      status.out_woken = out_kind_ff == KIND_WOKEN;
      status.out_last = out_last_ff;
   end

   assign rsp_kind = out_kind_ff;
   assign rsp_woken_thread = out_tid_ff;
   assign rsp_last_result = out_last_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(QUEUE_DEPTH))
      else $error("occupancy exceeds queue depth");

   a_place_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.place |-> !status.full)
      else $error("entry placed into a full queue");

   a_woken_is_due: assert property (@(posedge clock) disable iff (reset)
      cmd.out_wake |-> rd_data_ff.wake <= tick_ff)
      else $error("released an entry whose wake time is not reached");

   a_commit_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (idx_ff <= occ_ff) && ((emit_ff + OCC_W'(1)) == idx_ff))
      else $error("drain commit does not match the released count");

endmodule

FILE: src/sstq_controller.sv
module sstq_controller
   import sstq_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_op,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   input  status_type status,
   output cmd_type cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MUL = 4'd1;
   localparam logic [3:0] S_ADD = 4'd2;
   localparam logic [3:0] S_INS_CHK = 4'd3;
   localparam logic [3:0] S_INS_RD = 4'd4;
   localparam logic [3:0] S_INS_EV = 4'd5;
   localparam logic [3:0] S_PLACE = 4'd6;
   localparam logic [3:0] S_CNT_CHK = 4'd7;
   localparam logic [3:0] S_CNT_RD = 4'd8;
   localparam logic [3:0] S_CNT_EV = 4'd9;
   localparam logic [3:0] S_EMIT_RD = 4'd10;
   localparam logic [3:0] S_EMIT_LD = 4'd11;
   localparam logic [3:0] S_RESP = 4'd12;

   logic [3:0] state_ff, state_in;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = state_ff == S_RESP;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_INSERT) begin
                  cmd.cap_insert = 1'b1;
                  state_in = S_MUL;
               end else begin
                  cmd.cap_tick = 1'b1;
                  state_in = S_CNT_CHK;
               end
            end
         end
         S_MUL: begin
            cmd.mul = 1'b1;
            state_in = S_ADD;
         end
         S_ADD: begin
            cmd.add = 1'b1;
            state_in = S_INS_CHK;
         end
         S_INS_CHK: begin
            if (status.full) begin
               cmd.out_ins = 1'b1;
               state_in = S_RESP;
            end else if (status.idx_zero) begin
               state_in = S_PLACE;
            end else begin
               state_in = S_INS_RD;
            end
         end
         S_INS_RD: begin
            cmd.rd_ins = 1'b1;
            state_in = S_INS_EV;
         end
         S_INS_EV: begin
            // A strictly later neighbor moves up one place; an equal one stays ahead.
            if (status.later) begin
               cmd.shift = 1'b1;
               state_in = S_INS_CHK;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            cmd.place = 1'b1;
            cmd.out_ins = 1'b1;
            state_in = S_RESP;
         end
         S_CNT_CHK: begin
            if (!status.cnt_stop) begin
               state_in = S_CNT_RD;
            end else if (status.idx_zero) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_EMIT_RD;
            end
         end
         S_CNT_RD: begin
            cmd.rd_cnt = 1'b1;
            state_in = S_CNT_EV;
         end
         S_CNT_EV: begin
            if (status.due) begin
               cmd.cnt_inc = 1'b1;
               state_in = S_CNT_CHK;
            end else if (status.idx_zero) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_EMIT_RD;
            end
         end
         S_EMIT_RD: begin
            cmd.rd_emit = 1'b1;
            state_in = S_EMIT_LD;
         end
         S_EMIT_LD: begin
            cmd.out_wake = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               if (status.out_woken) begin
                  cmd.emit_inc = 1'b1;
                  if (status.out_last) begin
                     cmd.commit = 1'b1;
                     state_in = S_IDLE;
                  end else begin
                     state_in = S_EMIT_RD;
                  end
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_resp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(state_ff))
      else $error("pending result dropped before its transfer");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.cap_insert || cmd.cap_tick) |-> state_ff == S_IDLE)
      else $error("item captured while a previous item is in progress");

   a_commit_last: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> status.out_last && status.out_woken)
      else $error("drain committed before its final result");

endmodule

FILE: src/sorted_sleep_timer_queue.sv
// Deadline-ordered sleep queue of thread ids.
// Request channel (req_bus): op selects insert or tick; an insert carries a thread id
// and a delay in seconds. Result channel (rsp_bus): kind, woken_thread, last_result.
// csr_write_enable/csr_write_data load ticks per second; write it only while idle.
// An insert gives exactly one result (accepted, or full when the table holds
// QUEUE_DEPTH entries). A full answer skips the table walk. An accepted insert moves
// each later entry up one slot, and a compare with an entry that is not later, or
// reaching the front, stops the walk; the sorted table is walked one read and one
// write at a time on a single memory port.
// A tick advances the counter and releases up to 16 due head entries, one result each
// with the last one marked; it first counts the due entries, then releases each one,
// waiting on rsp_bus.ready for each result. A tick with nothing due returns to idle
// after its transfer and gives no result.
// One item is handled at a time: req_bus.ready is high only while idle.
// A stalled receiver holds the result steady in its output register until transfer.
// Reset clears the tick counter, the table occupancy and the control state and sets
// ticks per second to 1000; table contents are not cleared, no clearing pass is needed.
module sorted_sleep_timer_queue
   import sstq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   sstq_req_if.sink req_bus,
   sstq_rsp_if.source rsp_bus,
   input  logic csr_write_enable,
   input  logic [15:0] csr_write_data
);

   cmd_type cmd;
   status_type status;

   sstq_controller u_ctl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_bus.valid),
      .req_op(req_bus.op),
      .req_ready(req_bus.ready),
      .rsp_valid(rsp_bus.valid),
      .rsp_ready(rsp_bus.ready),
      .status(status),
      .cmd(cmd)
   );

   sstq_datapath #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .req_thread_id(req_bus.thread_id),
      .req_delay_seconds(req_bus.delay_seconds),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .rsp_kind(rsp_bus.kind),
      .rsp_woken_thread(rsp_bus.woken_thread),
      .rsp_last_result(rsp_bus.last_result)
   );

endmodule
